@@ src/parallel_camera_capture_packer_macros.svh @@
// Assertion macros used by the camera capture packer checker
`ifndef PARALLEL_CAMERA_CAPTURE_PACKER_MACROS_SVH
`define PARALLEL_CAMERA_CAPTURE_PACKER_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet during rst
`define PCCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, quiet during rst
`define PCCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pccp_pkg.sv @@
// Shared widths, constants and types for the camera capture packer
package pccp_pkg;

  // Field widths of the pin sample and result words
  localparam int PIN_W   = 8;
  localparam int PIX_W   = 6;
  localparam int WORD_W  = 32;
  localparam int INDEX_W = 10;
  localparam int WPB_W   = 11;

  // Buffer length arithmetic: wide enough for the register and the largest buffer
  localparam int LEN_W = 13;

  // Register map
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_WPB_ADDR = 2'd0;
  localparam logic [WPB_W-1:0]   WPB_RESET    = 11'd320;

  typedef struct packed {
    logic                 buffer_select;
    logic [INDEX_W-1:0]   word_index;
    logic [WORD_W-1:0]    packed_word;
    logic                 buffer_complete;
    logic                 ready_flag;
  } result_t;

endpackage

@@ src/pccp_sample_if.sv @@
// Channel carrying one sample of the camera pins
interface pccp_sample_if import pccp_pkg::*;;
  logic             valid;
  logic             ready;
  logic             pixel_clock;
  logic             frame_sync;
  logic             line_sync;
  logic [PIN_W-1:0] pixel_pins;
  logic             start_request;

  modport source (output valid, pixel_clock, frame_sync, line_sync, pixel_pins,
                  start_request, input ready);
  modport sink   (input valid, pixel_clock, frame_sync, line_sync, pixel_pins,
                  start_request, output ready);
endinterface

@@ src/pccp_result_if.sv @@
// Channel carrying one packed pixel word
interface pccp_result_if import pccp_pkg::*;;
  logic               valid;
  logic               ready;
  logic               buffer_select;
  logic [INDEX_W-1:0] word_index;
  logic [WORD_W-1:0]  packed_word;
  logic               buffer_complete;
  logic               ready_flag;

  modport source (output valid, buffer_select, word_index, packed_word, buffer_complete,
                  ready_flag, input ready);
  modport sink   (input valid, buffer_select, word_index, packed_word, buffer_complete,
                  ready_flag, output ready);
endinterface

@@ src/parallel_camera_capture_packer.sv @@
// Camera pin sampler that packs 6-bit pixels into ping-pong buffer words
//
//  channel   dir   handshake       payload
//  sample    in    valid/ready     pixel_clock frame_sync line_sync pixel_pins start_request
//  result    out   valid/ready     buffer_select word_index packed_word buffer_complete ready_flag
//  apb       in    psel/penable    paddr pwdata (words_per_buffer at 0x0), prdata, pready
//
// One sample is taken per cycle while sample.ready is high; sequencer state and pixel packing
// update in that cycle; a finished word lands in the output or skid register at the same edge.
// A two-entry output stage (register plus skid) lets sampling go on while a word waits.
// sample.ready drops only when both output entries hold words.
// rst is synchronous and returns the sequencer to waiting for a start request.
module parallel_camera_capture_packer import pccp_pkg::*; #(
  parameter int MAX_BUFFER_WORDS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  pccp_sample_if.sink         sample,
  pccp_result_if.source       result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int WC_W = (MAX_BUFFER_WORDS > 1) ? $clog2(MAX_BUFFER_WORDS) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BUFFER_WORDS);

  typedef enum logic [2:0] {
    PH_WAIT_START,
    PH_WAIT_FRAME,
    PH_WAIT_LINE,
    PH_WAIT_LOW,
    PH_WAIT_HIGH
  } phase_t;

  logic [WPB_W-1:0]   words_per_buffer;
  phase_t             phase, phase_next;
  logic [1:0]         pixel_count, pixel_count_next;
  logic [WC_W-1:0]    word_count, word_count_next;
  logic               current_buffer, current_buffer_next;
  logic [3*8-1:0]     partial_word, partial_word_next;
  logic               ready_sticky, ready_sticky_next;

  logic               out_valid, skid_valid;
  result_t            out_word, skid_word, new_word;

  logic               take, emit, done;
  logic [PIX_W-1:0]   pix;
  logic [LEN_W-1:0]   buf_len, wc_plus;
  logic [31:0]        wc_ext;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_WPB_ADDR) ? PDATA_W'(words_per_buffer) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_per_buffer <= WPB_RESET;
    end else if (psel && penable && pwrite && paddr == REG_WPB_ADDR) begin
      words_per_buffer <= pwdata[WPB_W-1:0];
    end
  end

  // Effective buffer length, clamped to 1..MAX_BUFFER_WORDS
  always_comb begin
    buf_len = LEN_W'(words_per_buffer);
    if (words_per_buffer == '0) begin
      buf_len = LEN_W'(1);
    end else if (buf_len > MAX_LEN) begin
      buf_len = MAX_LEN;
    end
  end

  assign take    = sample.valid && sample.ready;
  assign pix     = sample.pixel_pins[PIN_W-1:PIN_W-PIX_W];
  assign wc_plus = LEN_W'(word_count) + LEN_W'(1);
  assign done    = wc_plus >= buf_len;
  assign wc_ext  = 32'(word_count);

  // Candidate result word from the current partial word and this pixel
  always_comb begin
    new_word.buffer_select   = current_buffer;
    new_word.word_index      = wc_ext[INDEX_W-1:0];
    new_word.packed_word     = {partial_word, 2'b00, pix};
    new_word.buffer_complete = done;
    new_word.ready_flag      = ready_sticky | done;
  end

  // Capture sequencer
  always_comb begin
    phase_next          = phase;
    pixel_count_next    = pixel_count;
    word_count_next     = word_count;
    current_buffer_next = current_buffer;
    partial_word_next   = partial_word;
    ready_sticky_next   = ready_sticky;
    emit                = 1'b0;
    if (take) begin
      case (phase)
        PH_WAIT_START: if (sample.start_request) phase_next = PH_WAIT_FRAME;
        PH_WAIT_FRAME: if (sample.frame_sync)    phase_next = PH_WAIT_LINE;
        PH_WAIT_LINE:  if (sample.line_sync)     phase_next = PH_WAIT_LOW;
        PH_WAIT_LOW:   if (!sample.pixel_clock)  phase_next = PH_WAIT_HIGH;
        PH_WAIT_HIGH: begin
          if (sample.pixel_clock) begin
            if (pixel_count != 2'd3) begin
              partial_word_next = {partial_word[15:0], 2'b00, pix};
              pixel_count_next  = pixel_count + 2'd1;
              phase_next        = PH_WAIT_LOW;
            end else begin
              emit              = 1'b1;
              pixel_count_next  = '0;
              partial_word_next = '0;
              if (done) begin
                ready_sticky_next   = 1'b1;
                word_count_next     = '0;
                current_buffer_next = ~current_buffer;
                phase_next          = PH_WAIT_FRAME;
              end else begin
                word_count_next = word_count + WC_W'(1);
                phase_next      = PH_WAIT_LINE;
              end
            end
          end
        end
        default: phase_next = PH_WAIT_START;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT_START;
      pixel_count    <= '0;
      word_count     <= '0;
      current_buffer <= 1'b0;
      partial_word   <= '0;
      ready_sticky   <= 1'b0;
    end else begin
      phase          <= phase_next;
      pixel_count    <= pixel_count_next;
      word_count     <= word_count_next;
      current_buffer <= current_buffer_next;
      partial_word   <= partial_word_next;
      ready_sticky   <= ready_sticky_next;
    end
  end

  // Output register with skid entry
  assign sample.ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      out_word <= skid_valid ? skid_word : new_word;
    end else if (emit) begin
      skid_word <= new_word;
    end
  end

  assign result.valid           = out_valid;
  assign result.buffer_select   = out_word.buffer_select;
  assign result.word_index      = out_word.word_index;
  assign result.packed_word     = out_word.packed_word;
  assign result.buffer_complete = out_word.buffer_complete;
  assign result.ready_flag      = out_word.ready_flag;

endmodule

@@ src/pccp_checker.sv @@
// Port-level checks for the camera capture packer, bound to the top level
`include "parallel_camera_capture_packer_macros.svh"

module pccp_checker import pccp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_ready,
  input logic               r_valid,
  input logic               r_ready,
  input logic [INDEX_W-1:0] r_index,
  input logic [WORD_W-1:0]  r_word,
  input logic               r_complete,
  input logic               r_ready_flag
);

  logic seen_ready;

  // Remember that a word has already shown the sticky flag
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_ready <= 1'b0;
    end else if (r_valid && r_ready_flag) begin
      seen_ready <= 1'b1;
    end
  end

  `PCCP_ASSERT_NXT(a_word_held, r_valid && !r_ready, r_valid && $stable(r_word) && $stable(r_index), "result word changed while stalled")
  `PCCP_ASSERT_IMP(a_complete_flags, r_valid && r_complete, r_ready_flag, "buffer end without ready flag")
  `PCCP_ASSERT_IMP(a_flag_sticky, r_valid && seen_ready, r_ready_flag, "ready flag fell after being set")
  `PCCP_ASSERT_IMP(a_stall_only_full, !s_ready, r_valid, "sample stalled with empty output")

endmodule

bind parallel_camera_capture_packer pccp_checker u_pccp_checker (
  .clk          (clk),
  .rst          (rst),
  .s_ready      (sample.ready),
  .r_valid      (result.valid),
  .r_ready      (result.ready),
  .r_index      (result.word_index),
  .r_word       (result.packed_word),
  .r_complete   (result.buffer_complete),
  .r_ready_flag (result.ready_flag)
);
